### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU page replacement package
// Field widths, result layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int PAGE_W     = 16;
    localparam int SLOT_W     = 4;
    localparam int USE_W      = 16;
    localparam int FAULT_W    = 32;
    localparam int CFG_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Result tdata layout, lowest bit first
    localparam int OUT_SLOT_LSB  = 0;
    localparam int OUT_EVV_LSB   = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_EVP_LSB   = OUT_EVV_LSB + 1;
    localparam int OUT_FAULT_LSB = OUT_EVP_LSB + PAGE_W;
    localparam int OUT_USED_W    = OUT_FAULT_LSB + FAULT_W;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int IN_TDATA_W    = ((PAGE_W + 7) / 8) * 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture item, start scan
        logic issue;    // read one slot, advance scan index
        logic commit;   // write back and load result register
    } lfu_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_issue;   // scan index is on the final slot
        logic out_busy;     // result register full and not taken this cycle
    } lfu_status_t;

endpackage

### hw/rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU controller
// Sequences accept, slot scan, final evaluation and write-back per item.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    cmd
);

    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINAL  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.load   = in_ready && in_valid;
    assign cmd.issue  = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT) && !status.out_busy;

endmodule

### hw/rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// LFU datapath
// Slot tables, scan for match and minimum count, write-back, result register.
// ----------------------------------------------------------------------------
module lfu_datapath #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [lfu_pkg::PAGE_W-1:0]      in_page,
    input  lfu_pkg::lfu_cmd_t               cmd,
    output lfu_pkg::lfu_status_t            status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_hit,
    output logic [lfu_pkg::OUT_TDATA_W-1:0] out_data
);

    import lfu_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    // Configuration and persistent state
    logic [CFG_W-1:0]      cfg_reg;
    logic [MAX_FRAMES-1:0] slot_valid_reg;
    logic [IDX_W-1:0]      ptr_reg;
    logic [FAULT_W-1:0]    faults_reg;

    // Per-item scan state
    logic [PAGE_W-1:0]     page_reg;
    logic [CNT_W-1:0]      f_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      k_reg;
    logic                  eval_en_reg;
    logic                  eval_first_reg;
    logic [IDX_W-1:0]      eval_idx_reg;
    logic                  match_found_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    logic [USE_W-1:0]      match_cnt_reg;
    logic [USE_W-1:0]      best_cnt_reg;
    logic [IDX_W-1:0]      victim_idx_reg;
    logic                  victim_valid_reg;
    logic [PAGE_W-1:0]     victim_page_reg;

    // Result register
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [CNT_W-1:0]  f_active;
    logic [CNT_W-1:0]  ptr_ext;
    logic [IDX_W-1:0]  start_idx;
    logic [CNT_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  idx_wrap;
    logic [PAGE_W-1:0] page_rd;
    logic [USE_W-1:0]  cnt_rd;
    logic              eval_slot_valid;
    logic [USE_W-1:0]  eval_cnt;
    logic              eval_match;
    logic [CNT_W-1:0]  victim_inc;
    logic [IDX_W-1:0]  ptr_after;
    logic [FAULT_W-1:0] faults_inc;
    logic [USE_W-1:0]  match_cnt_inc;
    logic              cnt_wr_en;
    logic [IDX_W-1:0]  cnt_wr_addr;
    logic [USE_W-1:0]  cnt_wr_data;
    logic              page_wr_en;
    logic [OUT_TDATA_W-1:0] result_data;

    // Clamp the frame count: zero acts as one, above the table acts as full
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            f_active = CNT_W'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_FRAMES))
        begin
            f_active = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            f_active = CNT_W'(cfg_reg);
        end
    end

    // A pointer at or past the frame count restarts at slot 0
    assign ptr_ext   = CNT_W'(ptr_reg);
    assign start_idx = (ptr_ext >= f_active) ? '0 : ptr_reg;

    // Cyclic scan index
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_wrap = (idx_inc >= f_reg) ? '0 : IDX_W'(idx_inc);

    assign status.last_issue = (k_reg == f_reg - CNT_W'(1));
    assign status.out_busy   = out_valid_reg && !out_ready;

    lfu_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .clk     (clk),
        .wr_en   (page_wr_en),
        .wr_addr (victim_idx_reg),
        .wr_data (page_reg),
        .rd_addr (idx_reg),
        .rd_data (page_rd)
    );

    lfu_ram #(
        .WIDTH (USE_W),
        .DEPTH (MAX_FRAMES)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (idx_reg),
        .rd_data (cnt_rd)
    );

    // Evaluate the slot read in the previous cycle; empty slots count as zero
    assign eval_slot_valid = slot_valid_reg[eval_idx_reg];
    assign eval_cnt        = eval_slot_valid ? cnt_rd : '0;
    assign eval_match      = eval_slot_valid && (page_rd == page_reg);

    // Write-back values
    assign victim_inc    = CNT_W'(victim_idx_reg) + CNT_W'(1);
    assign ptr_after     = (victim_inc >= f_reg) ? '0 : IDX_W'(victim_inc);
    assign faults_inc    = (faults_reg == '1) ? faults_reg : faults_reg + FAULT_W'(1);
    assign match_cnt_inc = (match_cnt_reg == '1) ? match_cnt_reg
                                                 : match_cnt_reg + USE_W'(1);

    assign cnt_wr_en   = cmd.commit;
    assign cnt_wr_addr = match_found_reg ? match_idx_reg : victim_idx_reg;
    assign cnt_wr_data = match_found_reg ? match_cnt_inc : '0;
    assign page_wr_en  = cmd.commit && !match_found_reg;

    always_comb
    begin
        result_data = '0;
        if (match_found_reg)
        begin
            result_data[OUT_SLOT_LSB +: SLOT_W]   = SLOT_W'(match_idx_reg);
            result_data[OUT_FAULT_LSB +: FAULT_W] = faults_reg;
        end
        else
        begin
            result_data[OUT_SLOT_LSB +: SLOT_W]   = SLOT_W'(victim_idx_reg);
            result_data[OUT_EVV_LSB]              = victim_valid_reg;
            result_data[OUT_EVP_LSB +: PAGE_W]    = victim_valid_reg ? victim_page_reg : '0;
            result_data[OUT_FAULT_LSB +: FAULT_W] = faults_inc;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            slot_valid_reg <= '0;
            ptr_reg        <= '0;
            faults_reg     <= '0;
            eval_en_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            eval_en_reg <= cmd.issue;
            if (cmd.commit && !match_found_reg)
            begin
                slot_valid_reg[victim_idx_reg] <= 1'b1;
                ptr_reg                        <= ptr_after;
                faults_reg                     <= faults_inc;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg        <= in_page;
            f_reg           <= f_active;
            idx_reg         <= start_idx;
            k_reg           <= '0;
            eval_first_reg  <= 1'b1;
            match_found_reg <= 1'b0;
        end
        if (cmd.issue)
        begin
            idx_reg      <= idx_wrap;
            k_reg        <= k_reg + CNT_W'(1);
            eval_idx_reg <= idx_reg;
        end
        if (eval_en_reg)
        begin
            eval_first_reg <= 1'b0;
            // Lowest-numbered match wins
            if (eval_match && (!match_found_reg || eval_idx_reg < match_idx_reg))
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= eval_idx_reg;
                match_cnt_reg   <= eval_cnt;
            end
            // Strictly smaller keeps the first slot met from the pointer on ties
            if (eval_first_reg || eval_cnt < best_cnt_reg)
            begin
                best_cnt_reg     <= eval_cnt;
                victim_idx_reg   <= eval_idx_reg;
                victim_valid_reg <= eval_slot_valid;
                victim_page_reg  <= page_rd;
            end
        end
        if (cmd.commit)
        begin
            out_hit_reg  <= match_found_reg;
            out_data_reg <= result_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/lfu_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LFU page replacement top level
// Least-frequently-used frame replacement over a table of frame slots.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    tdata[15:0] page
// m_axis    out        m_axis_tvalid/m_axis_tready    tuser hit; tdata slot,
//                                                     evicted_valid, evicted_page,
//                                                     fault_total
// cfg       in         cfg_wr_en                      cfg_wr_data frames_in_use
//
// An item passes through accept, scan, evaluate and write-back states in that
// order. The scan visits the F active frame slots (F from 1 to MAX_FRAMES) and
// reads one slot per cycle through the read port of the page and count RAMs;
// the evaluate state handles the last slot read, then write-back follows.
// Reset clears slot valid bits, pointer and fault total, sets the frames register
// to 16 at once; page and count RAM contents are masked by the valid bits.
// A new item is accepted while the previous result waits on m_axis; the
// write-back of that new item holds until the result register has been taken.
//
module lfu_page_replacement_top #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: frames_in_use
    input  logic                            cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0]       cfg_wr_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lfu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] page
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] slot, [4] evicted_valid,
                                                            // [20:5] evicted_page,
                                                            // [52:21] fault_total, rest zero
    output logic                            m_axis_tuser    // [0] hit
);

    import lfu_pkg::*;

`include "assert_macros.svh"

    lfu_cmd_t    cmd;
    lfu_status_t status;

    // Sequence each item through accept, scan, evaluate and write-back
    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the slot tables and produce the result
    lfu_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_page     (s_axis_tdata[PAGE_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_hit     (m_axis_tuser),
        .out_data    (m_axis_tdata)
    );

    // Write-back never overwrites a result that is still waiting
    `ASSERT_IMPL(a_commit_no_overwrite, clk, rst_n, cmd.commit, !(m_axis_tvalid && !m_axis_tready))

    // Only one item in work at a time
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // The controller never scans and writes back in the same cycle, nor while idle
    `ASSERT_PROP(a_cmd_exclusive, clk, rst_n, !(cmd.issue && cmd.commit) && !(s_axis_tready && (cmd.issue || cmd.commit)))

    // A hit result carries no eviction
    `ASSERT_IMPL(a_hit_no_evict, clk, rst_n, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[OUT_EVV_LSB])

endmodule
